// ===== src/spm_pkg.sv =====
// Package for the stream pattern mask block.
// Payload structs, configuration register indexes and constants.
// No dependencies.
package spm_pkg;

    localparam int KEY_MAX_DEF = 16;
    localparam int LEN_W       = 5;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 2;

    localparam logic [7:0] MASK_CHAR = 8'd42;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_LENGTH = 2'd0,
        CFG_KEY_LOW    = 2'd1,
        CFG_KEY_HIGH   = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       stream_end;
    } out_item_t;

endpackage

// ===== src/stream_pattern_mask.sv =====
// Stream pattern mask top level: key search window and result buffer.
// Depends on spm_pkg.
//
// Usage:
// - Input channel (in_valid / in_stall / in_data) takes one text byte per
//   transfer; in_last marks the final byte of a stream.
// - Output channel (out_valid / out_stall / out_data) gives the text back
//   with each non-overlapping key occurrence replaced by asterisks.
//   run_last flags the last result of an input byte, stream_end the final
//   byte of a stream.
// - cfg_write / cfg_index / cfg_data write key length and key bytes; write
//   only while the block is idle.
// - Results pass from the input register into the result buffer.
// - Throughput: one input byte per cycle while each byte yields at most one
//   result and out_stall is low. A byte with k results (match or end flush)
//   holds the result buffer until all k drain; the input register then takes
//   one more byte and stalls. The result buffer shift register sets the rate.
// - Reset empties the window and the result buffer; key length returns to
//   one and key bytes to zero.
// - A stalled receiver holds the current result; the input side stalls
//   once the input register is also full.
module stream_pattern_mask #(
    parameter int KEY_MAX = spm_pkg::KEY_MAX_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  spm_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output spm_pkg::out_item_t            out_data,
    input  logic                          cfg_write,
    input  logic [spm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [spm_pkg::CFG_W-1:0]     cfg_data
);
    import spm_pkg::*;

    localparam int CW = $clog2(KEY_MAX + 1);
    localparam int IW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

    logic [LEN_W-1:0]   key_length_reg;
    logic [CFG_W-1:0]   key_low_reg;
    logic [CFG_W-1:0]   key_high_reg;

    logic               in_valid_reg;
    in_item_t           in_item_reg;

    logic [7:0]         win_reg [KEY_MAX];
    logic [CW-1:0]      count_reg;

    logic [7:0]         emit_reg [KEY_MAX];
    logic [CW-1:0]      emit_cnt_reg;
    logic               emit_end_reg;

    logic [2*CFG_W-1:0] key_cat;
    logic [7:0]         key_arr [KEY_MAX];
    logic [CW-1:0]      len;
    logic [7:0]         app [KEY_MAX];
    logic [CW-1:0]      n;
    logic [CW-1:0]      p;
    logic [CW-1:0]      m;
    logic               full;
    logic               match;
    logic [7:0]         emit_next [KEY_MAX];
    logic [7:0]         win_next [KEY_MAX];
    logic [CW-1:0]      count_next;
    logic               out_fire;
    logic               advance;

    assign key_cat = {key_high_reg, key_low_reg};

    always_comb
    begin
        for (int i = 0; i < KEY_MAX; i++)
        begin
            key_arr[i] = key_cat[8*i +: 8];
        end
    end

    always_comb
    begin
        if (key_length_reg == '0)
        begin
            len = CW'(1);
        end
        else if (key_length_reg > LEN_W'(KEY_MAX))
        begin
            len = CW'(KEY_MAX);
        end
        else
        begin
            len = CW'(key_length_reg);
        end
    end

    // one step: append, compare the newest len bytes, decide how many to emit
    always_comb
    begin
        logic [CW-1:0] idx;
        logic [CW:0]   sidx;
        n = count_reg + CW'(1);
        for (int j = 0; j < KEY_MAX; j++)
        begin
            app[j] = (CW'(j) == count_reg) ? in_item_reg.in_byte : win_reg[j];
        end
        full  = (n >= len);
        p     = full ? (n - len) : '0;
        match = 1'b1;
        for (int i = 0; i < KEY_MAX; i++)
        begin
            idx = p + CW'(i);
            if (CW'(i) < len && app[idx[IW-1:0]] != key_arr[i])
            begin
                match = 1'b0;
            end
        end
        if (full && (match || in_item_reg.in_last))
        begin
            m = n;
        end
        else if (full)
        begin
            m = p + CW'(1);
        end
        else if (in_item_reg.in_last)
        begin
            m = n;
        end
        else
        begin
            m = '0;
        end
        for (int j = 0; j < KEY_MAX; j++)
        begin
            emit_next[j] = (full && match && CW'(j) >= p) ? MASK_CHAR : app[j];
            sidx         = {1'b0, m} + (CW+1)'(j);
            win_next[j]  = (sidx < (CW+1)'(KEY_MAX)) ? app[sidx[IW-1:0]] : win_reg[j];
        end
        count_next = n - m;
    end

    assign out_valid           = (emit_cnt_reg != '0);
    assign out_fire            = out_valid && !out_stall;
    assign out_data.out_byte   = emit_reg[0];
    assign out_data.run_last   = (emit_cnt_reg == CW'(1));
    assign out_data.stream_end = (emit_cnt_reg == CW'(1)) && emit_end_reg;

    assign advance  = in_valid_reg &&
                      ((emit_cnt_reg == '0) || ((emit_cnt_reg == CW'(1)) && out_fire));
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg <= LEN_W'(1);
            key_low_reg    <= '0;
            key_high_reg   <= '0;
            in_valid_reg   <= 1'b0;
            count_reg      <= '0;
            emit_cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_KEY_LENGTH: key_length_reg <= cfg_data[LEN_W-1:0];
                    CFG_KEY_LOW:    key_low_reg    <= cfg_data;
                    CFG_KEY_HIGH:   key_high_reg   <= cfg_data;
                    default:        ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                count_reg    <= count_next;
                emit_cnt_reg <= m;
            end
            else if (out_fire)
            begin
                emit_cnt_reg <= emit_cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_item_reg <= in_data;
        end
        if (advance)
        begin
            win_reg      <= win_next;
            emit_reg     <= emit_next;
            emit_end_reg <= in_item_reg.in_last;
        end
        else if (out_fire)
        begin
            for (int j = 0; j < KEY_MAX - 1; j++)
            begin
                emit_reg[j] <= emit_reg[j+1];
            end
        end
    end

    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        emit_cnt_reg <= CW'(KEY_MAX))
        else $error("result buffer count exceeds window depth");

    a_window_room: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < CW'(KEY_MAX))
        else $error("window has no room for the next byte");

    a_emit_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && (emit_cnt_reg > CW'(1)) |=> emit_cnt_reg == $past(emit_cnt_reg) - CW'(1))
        else $error("result buffer did not drain by one");

    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_item_reg))
        else $error("pending input item lost");

endmodule
